FILE: hdl/rcf_pkg.sv
`default_nettype none

package rcf_pkg;

  // Microcode jump conditions
  localparam logic [1:0] COND_NEVER = 2'd0;
  localparam logic [1:0] COND_TICK  = 2'd1;
  localparam logic [1:0] COND_BUSY  = 2'd2;
  localparam logic [1:0] COND_LAST  = 2'd3;

  localparam int STEP_W = 2;

  // Step addresses
  localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
  localparam logic [STEP_W-1:0] STEP_UPDATE = 2'd1;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_ADV    = 2'd3;

  // Channel slots in the per-ring storage
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_LEVEL = 3;
  localparam int NUM_CH   = 4;

  localparam int LAYOUT_LAST = 6;

  // Reciprocal of five: x / 5 == (x * 205) >> 10 for x <= 255
  localparam logic [7:0] RECIP_FIVE = 8'd205;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              in_rdy;
    logic              clr_ring;
    logic              upd;
    logic              emit;
    logic              inc_ring;
    logic [1:0]        cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] seq;
  } ctrl_t;

  typedef struct packed {
    logic tick_acc;
    logic out_busy;
    logic ring_last;
  } stat_t;

  // Control store
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      STEP_WAIT: begin
        w.in_rdy = 1'b1; w.clr_ring = 1'b1;
        w.cond = COND_TICK; w.jmp = STEP_UPDATE; w.seq = STEP_WAIT;
      end
      STEP_UPDATE: begin
        w.upd = 1'b1;
        w.cond = COND_NEVER; w.jmp = STEP_UPDATE; w.seq = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_BUSY; w.jmp = STEP_EMIT; w.seq = STEP_ADV;
      end
      STEP_ADV: begin
        w.inc_ring = 1'b1;
        w.cond = COND_LAST; w.jmp = STEP_WAIT; w.seq = STEP_UPDATE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // LED strip layout, clamped past the last ring
  function automatic logic [7:0] ring_bound(input logic [4:0] z);
    logic [7:0] b;
    case ((z > 5'(LAYOUT_LAST)) ? 5'(LAYOUT_LAST) : z)
      5'd0:    b = 8'd0;
      5'd1:    b = 8'd8;
      5'd2:    b = 8'd24;
      5'd3:    b = 8'd48;
      5'd4:    b = 8'd80;
      5'd5:    b = 8'd116;
      default: b = 8'd160;
    endcase
    return b;
  endfunction

  // Step one fifth of the way to the goal, truncated toward zero
  function automatic logic [7:0] approach(input logic [7:0] cur, input logic [7:0] goal);
    logic [8:0]  diff;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [7:0]  q;
    diff = {1'b0, goal} - {1'b0, cur};
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    prod = 16'(mag) * 16'(RECIP_FIVE);
    q    = {2'b00, prod[15:10]};
    return diff[8] ? cur - q : cur + q;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ring_color_fader_top.sv
`default_nettype none

// Ring color fader. A set word (opcode 0) stores one ring's target color and
// brightness, and with jump_now also makes it the current value;
// ring indexes at or past NUM_RINGS are ignored. A tick word (opcode 1) walks
// the rings in order: for each ring the current channels move one fifth of the
// way to the target, then one output word gives the ring's LED span and its
// brightness-scaled pixel, with last_ring on the final ring. A small microcode
// program steps the datapath through update, emit and advance steps for each
// ring; the emit step waits while the previous output word is still held by
// back-pressure. Set words are taken back to back while no tick is in
// progress, and the next word is taken while the last output word still waits.
module ring_color_fader_top
  import rcf_pkg::*;
#(
  parameter int NUM_RINGS = 6
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        opcode,
  input  wire  [2:0] ring_index,
  input  wire  [7:0] target_red,
  input  wire  [7:0] target_green,
  input  wire  [7:0] target_blue,
  input  wire  [7:0] target_level,
  input  wire        jump_now,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] ring_number,
  output logic [7:0] first_led,
  output logic [5:0] led_count,
  output logic [7:0] pixel_red,
  output logic [7:0] pixel_green,
  output logic [7:0] pixel_blue,
  output logic       last_ring
);

  ctrl_t ctrl;
  stat_t stat;

  rcf_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  rcf_datapath #(
    .NUM_RINGS (NUM_RINGS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .ring_index   (ring_index),
    .target_red   (target_red),
    .target_green (target_green),
    .target_blue  (target_blue),
    .target_level (target_level),
    .jump_now     (jump_now),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ring_number  (ring_number),
    .first_led    (first_led),
    .led_count    (led_count),
    .pixel_red    (pixel_red),
    .pixel_green  (pixel_green),
    .pixel_blue   (pixel_blue),
    .last_ring    (last_ring)
  );

endmodule

`default_nettype wire

FILE: hdl/rcf_seq.sv
`default_nettype none

module rcf_seq
  import rcf_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic              take;

  assign ctrl = ucode(step);

  // Jump condition select
  always_comb begin
    case (ctrl.cond)
      COND_NEVER: take = 1'b0;
      COND_TICK:  take = stat.tick_acc;
      COND_BUSY:  take = stat.out_busy;
      COND_LAST:  take = stat.ring_last;
      default:    take = 1'b0;
    endcase
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= take ? ctrl.jmp : ctrl.seq;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rcf_datapath.sv
`default_nettype none

module rcf_datapath
  import rcf_pkg::*;
#(
  parameter int NUM_RINGS = 6
) (
  input  wire        clk,
  input  wire        rst,
  input  ctrl_t      ctrl,
  output stat_t      stat,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        opcode,
  input  wire  [2:0] ring_index,
  input  wire  [7:0] target_red,
  input  wire  [7:0] target_green,
  input  wire  [7:0] target_blue,
  input  wire  [7:0] target_level,
  input  wire        jump_now,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] ring_number,
  output logic [7:0] first_led,
  output logic [5:0] led_count,
  output logic [7:0] pixel_red,
  output logic [7:0] pixel_green,
  output logic [7:0] pixel_blue,
  output logic       last_ring
);

  localparam int RW = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int IW = (RW > 3) ? RW : 3;

  logic [7:0]    cur  [NUM_RINGS][NUM_CH];
  logic [7:0]    goal [NUM_RINGS][NUM_CH];
  logic [RW-1:0] ring;
  logic [IW-1:0] set_idx;
  logic          in_acc;
  logic          set_ok;
  logic          emit_fire;
  logic [7:0]    tgt [NUM_CH];
  logic [7:0]    pix [3];
  logic [7:0]    end_led;
  logic [7:0]    lvl;

  assign in_ready  = ctrl.in_rdy;
  assign in_acc    = in_valid & in_ready;
  assign set_idx   = IW'(ring_index);
  assign set_ok    = in_acc && (opcode == OP_SET) && (int'(ring_index) < NUM_RINGS);
  assign emit_fire = ctrl.emit & ~stat.out_busy;

  assign tgt[CH_RED]   = target_red;
  assign tgt[CH_GREEN] = target_green;
  assign tgt[CH_BLUE]  = target_blue;
  assign tgt[CH_LEVEL] = target_level;

  assign stat.tick_acc  = in_acc && (opcode == OP_TICK);
  assign stat.out_busy  = out_valid & ~out_ready;
  assign stat.ring_last = (ring == RW'(NUM_RINGS - 1));

  // Per-ring goal and current values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < NUM_RINGS; z++) begin
        for (int k = 0; k < NUM_CH; k++) begin
          cur[z][k]  <= 8'd0;
          goal[z][k] <= 8'd0;
        end
      end
    end else if (set_ok) begin
      for (int k = 0; k < NUM_CH; k++) begin
        goal[set_idx[RW-1:0]][k] <= tgt[k];
        if (jump_now) begin
          cur[set_idx[RW-1:0]][k] <= tgt[k];
        end
      end
    end else if (ctrl.upd) begin
      for (int k = 0; k < NUM_CH; k++) begin
        cur[ring][k] <= approach(cur[ring][k], goal[ring][k]);
      end
    end
  end

  // Ring counter
  always_ff @(posedge clk) begin
    if (rst) begin
      ring <= '0;
    end else if (ctrl.clr_ring) begin
      ring <= '0;
    end else if (ctrl.inc_ring && !stat.ring_last) begin
      ring <= ring + RW'(1);
    end
  end

  // Brightness scaling, +1 when both channel and level are nonzero
  assign lvl = cur[ring][CH_LEVEL];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pix[k] = 8'((16'(cur[ring][k]) * 16'(lvl)) >> 8)
             + 8'((cur[ring][k] != 8'd0) && (lvl != 8'd0));
    end
  end

  assign end_led = ring_bound(5'(ring) + 5'd1);

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      ring_number <= 3'(ring);
      first_led   <= ring_bound(5'(ring));
      led_count   <= 6'(end_led - ring_bound(5'(ring)));
      pixel_red   <= pix[CH_RED];
      pixel_green <= pix[CH_GREEN];
      pixel_blue  <= pix[CH_BLUE];
      last_ring   <= stat.ring_last;
    end
  end

endmodule

`default_nettype wire

FILE: bench/ring_color_fader_top_tb.sv
`timescale 1ns / 1ps

module ring_color_fader_top_tb;
  import rcf_pkg::*;

  localparam int RINGS        = 6;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 3 * RINGS + 6;
  localparam int TARGET_WORDS = 430;

  // LED strip layout, one entry past the last ring
  localparam bit [7:0] LED_BOUND [0:6] = '{8'd0, 8'd8, 8'd24, 8'd48, 8'd80, 8'd116, 8'd160};

  typedef struct {
    logic       op;
    logic [2:0] ring;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] level;
    logic       jump;
  } fade_cmd_t;

  typedef struct {
    logic [2:0] ring;
    logic [7:0] first;
    logic [5:0] count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } ring_pixel_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       opcode = 1'b0;
  logic [2:0] ring_index = 3'd0;
  logic [7:0] target_red = 8'd0;
  logic [7:0] target_green = 8'd0;
  logic [7:0] target_blue = 8'd0;
  logic [7:0] target_level = 8'd0;
  logic       jump_now = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] ring_number;
  logic [7:0] first_led;
  logic [5:0] led_count;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       last_ring;

  // Fader state mirror: current and goal per ring and channel
  logic [7:0] now_ch  [RINGS][NUM_CH];
  logic [7:0] goal_ch [RINGS][NUM_CH];

  fade_cmd_t   pending_cmds[$];
  ring_pixel_t expected_pixels[$];
  fade_cmd_t   on_wire;
  ring_pixel_t want;

  int total_words = 0;
  int words_in = 0;
  int words_out = 0;
  int fails = 0;
  int sets_done = 0;
  int sets_dropped = 0;
  int ticks_done = 0;
  int idle_cycles = 0;

  ring_color_fader_top #(.NUM_RINGS(RINGS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .ring_index(ring_index),
    .target_red(target_red), .target_green(target_green),
    .target_blue(target_blue), .target_level(target_level),
    .jump_now(jump_now),
    .out_valid(out_valid), .out_ready(out_ready),
    .ring_number(ring_number), .first_led(first_led), .led_count(led_count),
    .pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue),
    .last_ring(last_ring)
  );

  always #6 clk = ~clk;

  // One fifth of the way to the goal, truncated toward zero
  function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] goal);
    int gap;
    gap = int'(goal) - int'(cur);
    return 8'(int'(cur) + gap / 5);
  endfunction

  // Brightness scaling; black at zero level
  function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] lvl);
    logic [15:0] prod;
    if (lvl == 8'd0) return 8'd0;
    prod = 16'(c) * 16'(lvl);
    return prod[15:8] + ((c != 8'd0) ? 8'd1 : 8'd0);
  endfunction

  // Idle percentages for the three pacing phases
  function automatic int phase_of();
    if (words_in * 3 < total_words) return 0;
    if (words_in * 3 < total_words * 2) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (phase_of())
      0: return 37;
      1: return 69;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (phase_of())
      0: return 69;
      1: return 37;
      default: return 0;
    endcase
  endfunction

  // Apply an accepted word to the mirror; a tick queues one pixel per ring
  task automatic apply_cmd(input fade_cmd_t c);
    ring_pixel_t px;
    if (c.op == OP_SET) begin
      if (c.ring < RINGS) begin
        goal_ch[c.ring][CH_RED]   = c.red;
        goal_ch[c.ring][CH_GREEN] = c.green;
        goal_ch[c.ring][CH_BLUE]  = c.blue;
        goal_ch[c.ring][CH_LEVEL] = c.level;
        if (c.jump) now_ch[c.ring] = goal_ch[c.ring];
        sets_done++;
      end else begin
        sets_dropped++;
      end
    end else begin
      for (int z = 0; z < RINGS; z++)
        for (int k = 0; k < NUM_CH; k++)
          now_ch[z][k] = step_toward(now_ch[z][k], goal_ch[z][k]);
      for (int z = 0; z < RINGS; z++) begin
        px.ring  = 3'(z);
        px.first = LED_BOUND[z];
        px.count = 6'(LED_BOUND[z + 1] - LED_BOUND[z]);
        px.red   = dim_channel(now_ch[z][CH_RED], now_ch[z][CH_LEVEL]);
        px.green = dim_channel(now_ch[z][CH_GREEN], now_ch[z][CH_LEVEL]);
        px.blue  = dim_channel(now_ch[z][CH_BLUE], now_ch[z][CH_LEVEL]);
        px.last  = (z == RINGS - 1);
        expected_pixels.push_back(px);
      end
      ticks_done++;
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  task automatic push_cmd(input logic op, input logic [2:0] ring, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b, input logic [7:0] l,
                          input logic jump);
    fade_cmd_t c;
    c.op = op; c.ring = ring; c.red = r; c.green = g; c.blue = b; c.level = l;
    c.jump = jump;
    pending_cmds.push_back(c);
  endtask

  // Biased byte: extremes and small values show up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7, 0))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(6, 1));
      default: return 8'($urandom);
    endcase
  endfunction

  // Input driver: holds each word until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_cmd(on_wire);
        words_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
          on_wire = pending_cmds.pop_front();
          in_valid     <= 1'b1;
          opcode       <= on_wire.op;
          ring_index   <= on_wire.ring;
          target_red   <= on_wire.red;
          target_green <= on_wire.green;
          target_blue  <= on_wire.blue;
          target_level <= on_wire.level;
          jump_now     <= on_wire.jump;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out++;
        if (expected_pixels.size() == 0) begin
          $error("output word with nothing expected: ring_number %0d", ring_number);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("ring_number", int'(want.ring), int'(ring_number));
          check_field("first_led", int'(want.first), int'(first_led));
          check_field("led_count", int'(want.count), int'(led_count));
          check_field("pixel_red", int'(want.red), int'(pixel_red));
          check_field("pixel_green", int'(want.green), int'(pixel_green));
          check_field("pixel_blue", int'(want.blue), int'(pixel_blue));
          check_field("last_ring", int'(want.last), int'(last_ring));
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct());
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[ring_color_fader_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int z = 0; z < RINGS; z++)
      for (int k = 0; k < NUM_CH; k++) begin
        now_ch[z][k]  = 8'd0;
        goal_ch[z][k] = 8'd0;
      end

    // Directed: frame from reset, extremes, black level, zero channels
    push_cmd(OP_TICK, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_cmd(OP_SET, 3'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_cmd(OP_SET, 3'd1, 8'd255, 8'd0, 8'd128, 8'd1, 1'b1);
    push_cmd(OP_SET, 3'd2, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
    push_cmd(OP_SET, 3'd3, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
    push_cmd(OP_SET, 3'd4, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    push_cmd(OP_SET, 3'd5, 8'hAA, 8'h55, 8'h01, 8'h80, 1'b0);
    // out-of-range rings must leave state alone
    push_cmd(OP_SET, 3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_cmd(OP_SET, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_cmd(OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_cmd(OP_TICK, 3'd5, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 1'b1);
    // fade down and a gap too small to move
    push_cmd(OP_SET, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    push_cmd(OP_SET, 3'd4, 8'd3, 8'd4, 8'd252, 8'd251, 1'b1);
    push_cmd(OP_SET, 3'd4, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0);
    push_cmd(OP_TICK, 3'd3, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
    push_cmd(OP_TICK, 3'd1, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
    push_cmd(OP_TICK, 3'd2, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0);

    // Random: mostly valid sets with a tick about one word in four
    while (pending_cmds.size() < TARGET_WORDS) begin
      if ($urandom_range(3, 0) == 0)
        push_cmd(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'($urandom));
      else
        push_cmd(OP_SET,
                 ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 6))
                                             : 3'($urandom_range(5, 0)),
                 pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                 ($urandom_range(9, 0) < 3));
    end
    total_words = pending_cmds.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to go in and every pixel to come out
    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d words: %0d target sets, %0d out-of-range sets, %0d frame ticks.",
             words_in, sets_done, sets_dropped, ticks_done);
    $display("Checked %0d pixel words across three pacing phases; %0d mismatches.",
             words_out, fails);
    if (fails == 0) begin
      $display("[ring_color_fader_top] OK");
    end else begin
      $display("[ring_color_fader_top] ERROR");
    end
    $finish;
  end

endmodule
